### design/hid_report_message_reassembler_assert.svh
`ifndef HID_REPORT_MESSAGE_REASSEMBLER_ASSERT_SVH
`define HID_REPORT_MESSAGE_REASSEMBLER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HRMR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define HRMR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

### design/hrmr_pkg.sv
package hrmr_pkg;

    localparam int REPORT_BYTES = 64;
    localparam int POS_W        = $clog2(REPORT_BYTES);
    localparam int LEN_W        = 13;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd7609;
    localparam logic [7:0]       INIT_FLAG     = 8'h80;

    // Byte positions inside a report.
    localparam int POS_CMD          = 4;
    localparam int POS_LEN_HI       = 5;
    localparam int POS_LEN_LO       = 6;
    localparam int POS_INIT_PAYLOAD = 7;
    localparam int POS_CONT_PAYLOAD = 5;
    localparam int POS_LAST         = REPORT_BYTES - 1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] STATUS_INCOMPLETE = 2'd0;
    localparam logic [1:0] STATUS_COMPLETE   = 2'd1;
    localparam logic [1:0] STATUS_REJECTED   = 2'd2;

    // Result queue: one item can produce two results.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [3:0] {
        MODE_UNDECIDED = 4'b0001,
        MODE_INIT      = 4'b0010,
        MODE_CONT      = 4'b0100,
        MODE_REJECT    = 4'b1000
    } mode_t;

    typedef struct packed {
        logic             result_kind;
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] payload_offset;
        logic [1:0]       report_status;
        logic [31:0]      channel_id;
        logic [7:0]       command_byte;
        logic [15:0]      message_length;
    } result_t;

endpackage

### design/hrmr_in_if.sv
interface hrmr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       report_start;

    modport source (output valid, output data_byte, output report_start, input ready);
    modport sink (input valid, input data_byte, input report_start, output ready);
endinterface

### design/hrmr_out_if.sv
interface hrmr_out_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [7:0]                  payload_byte;
    logic [hrmr_pkg::LEN_W-1:0]  payload_offset;
    logic [1:0]                  report_status;
    logic [31:0]                 channel_id;
    logic [7:0]                  command_byte;
    logic [15:0]                 message_length;

    modport source (
        output valid, output result_kind, output payload_byte, output payload_offset,
        output report_status, output channel_id, output command_byte,
        output message_length, input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input payload_offset,
        input report_status, input channel_id, input command_byte,
        input message_length, output ready
    );
endinterface

### design/hid_report_message_reassembler.sv
// Reassembles messages from fixed-size HID reports fed one byte per item. Each
// accepted byte is decoded combinationally against the running session state and
// its results (a payload byte with its message offset, and after the last byte of a
// report an end-of-report status) are written into a four-entry result queue.
// The block takes one item per clock as long as the queue has room for two
// results; with the sink taking a result every cycle that is sustained. Results
// are registered into the queue before they reach the output. max_message_length
// is written through cfg_write_en/cfg_write_data; the user must do so only while
// the block is idle, which the block itself does not enforce. It resets to 7609.
module hid_report_message_reassembler (
    input  logic                       clk,
    input  logic                       rst_n,
    hrmr_in_if.sink                    in_item,
    hrmr_out_if.source                 out_item,
    input  logic                       cfg_write_en,
    input  logic [hrmr_pkg::LEN_W-1:0] cfg_write_data
);

    `include "hid_report_message_reassembler_assert.svh"

    localparam int POS_W = hrmr_pkg::POS_W;
    localparam int LEN_W = hrmr_pkg::LEN_W;

    logic [LEN_W-1:0]       max_len_reg;
    logic                   active_reg, active_next;
    logic [31:0]            channel_reg, channel_next;
    logic [7:0]             command_reg, command_next;
    logic [15:0]            exp_len_reg, exp_len_next;
    logic [LEN_W-1:0]       rcv_len_reg, rcv_len_next;
    logic [7:0]             exp_seq_reg, exp_seq_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [31:0]            in_chan_reg, in_chan_next;
    logic [7:0]             len_hi_reg, len_hi_next;
    hrmr_pkg::mode_t        mode_reg, mode_next;

    logic [POS_W-1:0]       pos_cur;
    hrmr_pkg::mode_t        mode_cur;
    logic [7:0]             b;
    logic [15:0]            ann_len;
    logic [POS_W-1:0]       first_payload;
    logic                   pay_valid;
    logic                   last_byte;
    logic [1:0]             status;
    hrmr_pkg::result_t      pay_res, stat_res;

    hrmr_pkg::result_t                   queue_reg [hrmr_pkg::OUT_DEPTH];
    logic [hrmr_pkg::OUT_PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [hrmr_pkg::OUT_CNT_W-1:0]      count_reg;
    logic [hrmr_pkg::OUT_CNT_W-1:0]      push_n;
    logic                                in_fire, out_fire;

    assign in_item.ready = (count_reg <= hrmr_pkg::OUT_CNT_W'(hrmr_pkg::OUT_DEPTH - 2));
    assign in_fire       = in_item.valid && in_item.ready;
    assign out_fire      = out_item.valid && out_item.ready;

    always_comb
    begin
        b            = in_item.data_byte;
        pos_cur      = in_item.report_start ? '0 : pos_reg;
        mode_cur     = (pos_cur == '0) ? hrmr_pkg::MODE_UNDECIDED : mode_reg;
        ann_len      = {len_hi_reg, b};
        first_payload = (mode_cur == hrmr_pkg::MODE_INIT)
                        ? POS_W'(hrmr_pkg::POS_INIT_PAYLOAD)
                        : POS_W'(hrmr_pkg::POS_CONT_PAYLOAD);

        active_next  = active_reg;
        channel_next = channel_reg;
        command_next = command_reg;
        exp_len_next = exp_len_reg;
        rcv_len_next = rcv_len_reg;
        exp_seq_next = exp_seq_reg;
        in_chan_next = in_chan_reg;
        len_hi_next  = len_hi_reg;
        mode_next    = mode_cur;
        pay_valid    = 1'b0;

        priority if (pos_cur < POS_W'(hrmr_pkg::POS_CMD))
        begin
            in_chan_next = {in_chan_reg[23:0], b};
        end
        else if (pos_cur == POS_W'(hrmr_pkg::POS_CMD))
        begin
            priority if ((b & hrmr_pkg::INIT_FLAG) != 8'h00)
            begin
                channel_next = in_chan_reg;
                command_next = b;
                active_next  = 1'b0;
                mode_next    = hrmr_pkg::MODE_INIT;
            end
            else if (!active_reg || (in_chan_reg != channel_reg))
            begin
                mode_next = hrmr_pkg::MODE_REJECT;
            end
            else if (b != exp_seq_reg)
            begin
                active_next = 1'b0;
                mode_next   = hrmr_pkg::MODE_REJECT;
            end
            else
            begin
                exp_seq_next = exp_seq_reg + 8'd1;
                mode_next    = hrmr_pkg::MODE_CONT;
            end
        end
        else if ((mode_cur == hrmr_pkg::MODE_INIT) && (pos_cur == POS_W'(hrmr_pkg::POS_LEN_HI)))
        begin
            len_hi_next = b;
        end
        else if ((mode_cur == hrmr_pkg::MODE_INIT) && (pos_cur == POS_W'(hrmr_pkg::POS_LEN_LO)))
        begin
            exp_len_next = ann_len;
            if (ann_len > {3'b000, max_len_reg})
            begin
                active_next = 1'b0;
                mode_next   = hrmr_pkg::MODE_REJECT;
            end
            else
            begin
                rcv_len_next = '0;
                exp_seq_next = '0;
                active_next  = 1'b1;
            end
        end
        else
        begin
            if (((mode_cur == hrmr_pkg::MODE_INIT) || (mode_cur == hrmr_pkg::MODE_CONT))
                && (pos_cur >= first_payload) && ({3'b000, rcv_len_reg} < exp_len_reg))
            begin
                pay_valid    = 1'b1;
                rcv_len_next = rcv_len_reg + LEN_W'(1);
            end
        end

        last_byte = (pos_cur == POS_W'(hrmr_pkg::POS_LAST));
        pos_next  = last_byte ? '0 : pos_cur + POS_W'(1);

        if ((mode_next == hrmr_pkg::MODE_REJECT) || (mode_next == hrmr_pkg::MODE_UNDECIDED))
        begin
            status = hrmr_pkg::STATUS_REJECTED;
        end
        else if ({3'b000, rcv_len_next} >= exp_len_next)
        begin
            status = hrmr_pkg::STATUS_COMPLETE;
        end
        else
        begin
            status = hrmr_pkg::STATUS_INCOMPLETE;
        end

        pay_res.result_kind    = hrmr_pkg::KIND_PAYLOAD;
        pay_res.payload_byte   = b;
        pay_res.payload_offset = rcv_len_reg;
        pay_res.report_status  = hrmr_pkg::STATUS_INCOMPLETE;
        pay_res.channel_id     = channel_next;
        pay_res.command_byte   = command_next;
        pay_res.message_length = exp_len_next;

        stat_res.result_kind    = hrmr_pkg::KIND_STATUS;
        stat_res.payload_byte   = '0;
        stat_res.payload_offset = '0;
        stat_res.report_status  = status;
        stat_res.channel_id     = channel_next;
        stat_res.command_byte   = command_next;
        stat_res.message_length = exp_len_next;

        push_n = in_fire ? (hrmr_pkg::OUT_CNT_W'(pay_valid) + hrmr_pkg::OUT_CNT_W'(last_byte))
                         : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= hrmr_pkg::MAX_LEN_RESET;
        end
        else if (cfg_write_en)
        begin
            max_len_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            channel_reg <= '0;
            command_reg <= '0;
            exp_len_reg <= '0;
            rcv_len_reg <= '0;
            exp_seq_reg <= '0;
            pos_reg     <= '0;
            in_chan_reg <= '0;
            len_hi_reg  <= '0;
            mode_reg    <= hrmr_pkg::MODE_UNDECIDED;
        end
        else if (in_fire)
        begin
            active_reg  <= active_next;
            channel_reg <= channel_next;
            command_reg <= command_next;
            exp_len_reg <= exp_len_next;
            rcv_len_reg <= rcv_len_next;
            exp_seq_reg <= exp_seq_next;
            pos_reg     <= pos_next;
            in_chan_reg <= in_chan_next;
            len_hi_reg  <= len_hi_next;
            mode_reg    <= mode_next;
        end
    end

    // The first slot takes the payload result if there is one, else the status.
    always_ff @(posedge clk)
    begin
        if (push_n != '0)
        begin
            queue_reg[wr_ptr_reg] <= pay_valid ? pay_res : stat_res;
        end
        if (push_n == hrmr_pkg::OUT_CNT_W'(2))
        begin
            queue_reg[wr_ptr_reg + hrmr_pkg::OUT_PTR_W'(1)] <= stat_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n[hrmr_pkg::OUT_PTR_W-1:0];
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + hrmr_pkg::OUT_PTR_W'(1);
            end
            count_reg <= count_reg + push_n - hrmr_pkg::OUT_CNT_W'(out_fire);
        end
    end

    assign out_item.valid          = (count_reg != '0);
    assign out_item.result_kind    = queue_reg[rd_ptr_reg].result_kind;
    assign out_item.payload_byte   = queue_reg[rd_ptr_reg].payload_byte;
    assign out_item.payload_offset = queue_reg[rd_ptr_reg].payload_offset;
    assign out_item.report_status  = queue_reg[rd_ptr_reg].report_status;
    assign out_item.channel_id     = queue_reg[rd_ptr_reg].channel_id;
    assign out_item.command_byte   = queue_reg[rd_ptr_reg].command_byte;
    assign out_item.message_length = queue_reg[rd_ptr_reg].message_length;

    `HRMR_ASSERT_IMP(a_queue_bound, 1'b1, count_reg <= hrmr_pkg::OUT_CNT_W'(hrmr_pkg::OUT_DEPTH))
    `HRMR_ASSERT_NEXT(a_last_byte_gives_result, in_fire && last_byte, out_item.valid && (pos_reg == '0))
    `HRMR_ASSERT_IMP(a_received_within_length, active_reg, {3'b000, rcv_len_reg} <= exp_len_reg)
    `HRMR_ASSERT_IMP(a_cont_needs_session, mode_reg == hrmr_pkg::MODE_CONT, active_reg)

endmodule
